// ===== src/ifr_pkg.sv =====
package ifr_pkg;

   localparam int MAX_DIM     = 64;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int SIZE_W      = DIM_W + 1;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int CFG_SIZE_W  = 7;
   localparam int CFG_MODE_W  = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 2;

   localparam int PIX_W       = 8;
   localparam int COORD_W     = 6;
   localparam int WORD_W      = 4 * PIX_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_ROTATION_MODE = 2'd2,
      CSR_ALPHA_PRESENT = 2'd3
   } csr_index_type;

   typedef enum logic [CFG_MODE_W-1:0] {
      ROT_CW90   = 2'd0,
      ROT_CCW90  = 2'd1,
      ROT_180    = 2'd2,
      ROT_180_B  = 2'd3
   } rot_mode_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EMIT = 1'b1
   } req_cmd_type;

   typedef enum logic {
      OUT_EMPTY = 1'b0,
      OUT_FULL  = 1'b1
   } out_state_type;

   typedef struct packed {
      logic load_en;
      logic emit_en;
   } dp_cmd_type;

   function automatic logic [SIZE_W-1:0] clamp_dim(input logic [CFG_SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = SIZE_W'(MAX_DIM);
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== src/ifr_req_if.sv =====
interface ifr_req_if;
   import ifr_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;
   logic [PIX_W-1:0] in_alpha;

   modport source (output valid, command, in_red, in_green, in_blue, in_alpha,
                   input ready);
   modport sink   (input valid, command, in_red, in_green, in_blue, in_alpha,
                   output ready);
endinterface

// ===== src/ifr_rsp_if.sv =====
interface ifr_rsp_if;
   import ifr_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   out_red;
   logic [PIX_W-1:0]   out_green;
   logic [PIX_W-1:0]   out_blue;
   logic [PIX_W-1:0]   out_alpha;
   logic [COORD_W-1:0] out_col;
   logic [COORD_W-1:0] out_row;
   logic               last_pixel;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, out_col,
                          out_row, last_pixel,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_col,
                         out_row, last_pixel,
                   output ready);
endinterface

// ===== src/image_frame_rotator_core.sv =====
// Frame rotator: stores one source image and reads it back rotated.
// req channel: each transaction carries a command. A load writes the pixel
// into the frame store at the next source position (row-major); it gives no
// response. An emit reads the next destination pixel (row-major order of the
// rotated image) and gives one rsp transaction with its colour bytes, its
// destination column and row, and last_pixel on the final one.
// csr port: write source_width, source_height, rotation_mode, alpha_present
// by index while no transaction is in flight.
// An emit's response is valid in the cycle after acceptance, set by the
// registered read of the frame store. One transaction is taken per cycle,
// loads and emits alike, while rsp is not stalled.
// When rsp is stalled the response holds and req_ch.ready drops, so no
// further transaction is taken until the held response is taken.
// Reset: registers return to 64 x 64, clockwise, alpha kept; position
// counters clear. Frame store contents are undefined until loaded.
module image_frame_rotator_core (
   input  logic                           clock,
   input  logic                           reset,
   ifr_req_if.sink                        req_ch,
   ifr_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_enable,
   input  logic [ifr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ifr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ifr_pkg::*;

   dp_cmd_type cmd;
   logic       req_ready;
   logic       rsp_valid;

   ifr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd)
   );

   ifr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .in_red           (req_ch.in_red),
      .in_green         (req_ch.in_green),
      .in_blue          (req_ch.in_blue),
      .in_alpha         (req_ch.in_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_red          (rsp_ch.out_red),
      .out_green        (rsp_ch.out_green),
      .out_blue         (rsp_ch.out_blue),
      .out_alpha        (rsp_ch.out_alpha),
      .out_col          (rsp_ch.out_col),
      .out_row          (rsp_ch.out_row),
      .last_pixel       (rsp_ch.last_pixel)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

// ===== src/ifr_ram.sv =====
module ifr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ifr_ctrl.sv =====
module ifr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_command,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ifr_pkg::dp_cmd_type cmd
);
   import ifr_pkg::*;

   out_state_type state_ff;
   out_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic take;
      take      = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         OUT_EMPTY: begin
            req_ready = 1'b1;
         end
         OUT_FULL: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               state_in = OUT_EMPTY;
            end
         end
         default: begin
            state_in = OUT_EMPTY;
         end
      endcase
      take        = req_valid && req_ready;
      cmd.load_en = take && (req_command == CMD_LOAD);
      cmd.emit_en = take && (req_command == CMD_EMIT);
      if (cmd.emit_en) begin
         state_in = OUT_FULL;
      end
   end

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> !(rsp_valid && !rsp_ready))
      else $error("emit issued over a held result");

   a_emit_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |=> rsp_valid)
      else $error("emit did not produce a result");

   a_cmd_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_en || cmd.emit_en) |-> (req_valid && req_ready))
      else $error("datapath command without accepted transaction");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.emit_en) |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule

// ===== src/ifr_datapath.sv =====
module ifr_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ifr_pkg::dp_cmd_type                cmd,
   input  logic [ifr_pkg::PIX_W-1:0]          in_red,
   input  logic [ifr_pkg::PIX_W-1:0]          in_green,
   input  logic [ifr_pkg::PIX_W-1:0]          in_blue,
   input  logic [ifr_pkg::PIX_W-1:0]          in_alpha,
   input  logic                               csr_write_enable,
   input  logic [ifr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ifr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic [ifr_pkg::PIX_W-1:0]          out_red,
   output logic [ifr_pkg::PIX_W-1:0]          out_green,
   output logic [ifr_pkg::PIX_W-1:0]          out_blue,
   output logic [ifr_pkg::PIX_W-1:0]          out_alpha,
   output logic [ifr_pkg::COORD_W-1:0]        out_col,
   output logic [ifr_pkg::COORD_W-1:0]        out_row,
   output logic                               last_pixel
);
   import ifr_pkg::*;

   logic [CFG_SIZE_W-1:0] source_width_ff;
   logic [CFG_SIZE_W-1:0] source_height_ff;
   logic [CFG_MODE_W-1:0] rotation_mode_ff;
   logic                  alpha_present_ff;

   logic [DIM_W-1:0] load_col_ff, load_col_in;
   logic [DIM_W-1:0] load_row_ff, load_row_in;
   logic [DIM_W-1:0] emit_col_ff, emit_col_in;
   logic [DIM_W-1:0] emit_row_ff, emit_row_in;

   logic [COORD_W-1:0] out_col_ff;
   logic [COORD_W-1:0] out_row_ff;
   logic               last_ff;
   logic               alpha_keep_ff;

   logic [SIZE_W-1:0] w, h, dw, dh;
   logic              quarter;
   logic [DIM_W-1:0]  lc, lr, ec, er;
   logic [SIZE_W-1:0] lc_inc, lr_inc, ec_inc, er_inc;
   logic [SIZE_W-1:0] src_col, src_row;
   logic              col_end, row_end;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= CFG_SIZE_W'(64);
         source_height_ff <= CFG_SIZE_W'(64);
         rotation_mode_ff <= ROT_CW90;
         alpha_present_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_write_data[CFG_SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_write_data[CFG_SIZE_W-1:0];
            CSR_ROTATION_MODE: rotation_mode_ff <= csr_write_data[CFG_MODE_W-1:0];
            CSR_ALPHA_PRESENT: alpha_present_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w       = clamp_dim(source_width_ff);
      h       = clamp_dim(source_height_ff);
      quarter = (rotation_mode_ff == ROT_CW90) || (rotation_mode_ff == ROT_CCW90);
      dw      = quarter ? h : w;
      dh      = quarter ? w : h;

      lc = (SIZE_W'(load_col_ff) >= w) ? '0 : load_col_ff;
      lr = (SIZE_W'(load_row_ff) >= h) ? '0 : load_row_ff;
      ec = (SIZE_W'(emit_col_ff) >= dw) ? '0 : emit_col_ff;
      er = (SIZE_W'(emit_row_ff) >= dh) ? '0 : emit_row_ff;

      lc_inc = SIZE_W'(lc) + SIZE_W'(1);
      lr_inc = SIZE_W'(lr) + SIZE_W'(1);
      ec_inc = SIZE_W'(ec) + SIZE_W'(1);
      er_inc = SIZE_W'(er) + SIZE_W'(1);

      load_col_in = load_col_ff;
      load_row_in = load_row_ff;
      if (cmd.load_en) begin
         if (lc_inc >= w) begin
            load_col_in = '0;
            load_row_in = (lr_inc >= h) ? '0 : lr_inc[DIM_W-1:0];
         end else begin
            load_col_in = lc_inc[DIM_W-1:0];
            load_row_in = lr;
         end
      end

      col_end = ec_inc >= dw;
      row_end = er_inc >= dh;
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      if (cmd.emit_en) begin
         if (col_end) begin
            emit_col_in = '0;
            emit_row_in = row_end ? '0 : er_inc[DIM_W-1:0];
         end else begin
            emit_col_in = ec_inc[DIM_W-1:0];
            emit_row_in = er;
         end
      end

      case (rot_mode_type'(rotation_mode_ff))
         ROT_CW90: begin
            src_col = SIZE_W'(er);
            src_row = h - SIZE_W'(1) - SIZE_W'(ec);
         end
         ROT_CCW90: begin
            src_col = w - SIZE_W'(1) - SIZE_W'(er);
            src_row = SIZE_W'(ec);
         end
         default: begin
            src_col = w - SIZE_W'(1) - SIZE_W'(ec);
            src_row = h - SIZE_W'(1) - SIZE_W'(er);
         end
      endcase

      wr_addr = {lr, lc};
      rd_addr = {src_row[DIM_W-1:0], src_col[DIM_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         load_row_ff <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
      end else begin
         load_col_ff <= load_col_in;
         load_row_ff <= load_row_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         out_col_ff    <= COORD_W'(ec);
         out_row_ff    <= COORD_W'(er);
         last_ff       <= col_end && row_end;
         alpha_keep_ff <= alpha_present_ff;
      end
   end

   ifr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .wr_addr (wr_addr),
      .wr_data ({in_alpha, in_blue, in_green, in_red}),
      .rd_en   (cmd.emit_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_red    = rd_data[PIX_W-1:0];
   assign out_green  = rd_data[2*PIX_W-1:PIX_W];
   assign out_blue   = rd_data[3*PIX_W-1:2*PIX_W];
   assign out_alpha  = alpha_keep_ff ? rd_data[4*PIX_W-1:3*PIX_W] : '0;
   assign out_col    = out_col_ff;
   assign out_row    = out_row_ff;
   assign last_pixel = last_ff;

endmodule

// ===== tb/image_frame_rotator_core_tb.sv =====
`timescale 1ns / 1ps

module image_frame_rotator_core_tb;
   import ifr_pkg::*;

   localparam int CLOCK_HIGH_NS = 4;
   localparam int CLOCK_LOW_NS  = 4;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 850;
   localparam int QUIET_AFTER   = 700;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PRESSURE_ROWS = 4;
   localparam int SIZE_REG_MAX  = (1 << CFG_SIZE_W) - 1;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [PIX_W-1:0]   alpha;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last_flag;
   } rotated_pixel_type;

   class rotation_tracker;
      logic [WORD_W-1:0]     frame [STORE_DEPTH];
      bit                    loaded [STORE_DEPTH];
      int unsigned           load_col, load_row, emit_col, emit_row;
      logic [CFG_SIZE_W-1:0] width_reg, height_reg;
      rot_mode_type          mode_reg;
      logic                  alpha_reg;
      rotated_pixel_type     upcoming_pixels [$];
      int unsigned           errors;

      function new();
         load_col   = 0;
         load_row   = 0;
         emit_col   = 0;
         emit_row   = 0;
         width_reg  = CFG_SIZE_W'(MAX_DIM);
         height_reg = CFG_SIZE_W'(MAX_DIM);
         mode_reg   = ROT_CW90;
         alpha_reg  = 1'b1;
         errors     = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SOURCE_WIDTH:  width_reg  = value[CFG_SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: height_reg = value[CFG_SIZE_W-1:0];
            CSR_ROTATION_MODE: mode_reg   = rot_mode_type'(value[CFG_MODE_W-1:0]);
            CSR_ALPHA_PRESENT: alpha_reg  = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned bounded(logic [CFG_SIZE_W-1:0] v);
         if (v == '0) return 1;
         if (int'(v) > MAX_DIM) return MAX_DIM;
         return int'(v);
      endfunction

      function bit quarter_turn();
         return mode_reg == ROT_CW90 || mode_reg == ROT_CCW90;
      endfunction

      function int unsigned dest_width();
         return quarter_turn() ? bounded(height_reg) : bounded(width_reg);
      endfunction

      function int unsigned dest_height();
         return quarter_turn() ? bounded(width_reg) : bounded(height_reg);
      endfunction

      function int unsigned source_pixels();
         return bounded(width_reg) * bounded(height_reg);
      endfunction

      function int unsigned dest_pixels();
         return dest_width() * dest_height();
      endfunction

      function int unsigned pending();
         return upcoming_pixels.size();
      endfunction

      function int unsigned emit_source_addr();
         int unsigned w, h, c, r, sc, sr;
         w = bounded(width_reg);
         h = bounded(height_reg);
         c = (emit_col >= dest_width()) ? 0 : emit_col;
         r = (emit_row >= dest_height()) ? 0 : emit_row;
         case (mode_reg)
            ROT_CW90: begin
               sc = r;
               sr = h - 1 - c;
            end
            ROT_CCW90: begin
               sc = w - 1 - r;
               sr = c;
            end
            default: begin
               sc = w - 1 - c;
               sr = h - 1 - r;
            end
         endcase
         return sr * MAX_DIM + sc;
      endfunction

      function bit emit_is_safe();
         return loaded[emit_source_addr()];
      endfunction

      function void note_request(req_cmd_type cmd, logic [WORD_W-1:0] pixel);
         int unsigned       w, h, dw, dh, addr;
         logic [WORD_W-1:0] word;
         rotated_pixel_type px;
         w  = bounded(width_reg);
         h  = bounded(height_reg);
         dw = dest_width();
         dh = dest_height();
         if (cmd == CMD_LOAD) begin
            if (load_col >= w) load_col = 0;
            if (load_row >= h) load_row = 0;
            addr         = load_row * MAX_DIM + load_col;
            frame[addr]  = pixel;
            loaded[addr] = 1'b1;
            if (load_col + 1 >= w) begin
               load_col = 0;
               load_row = (load_row + 1 >= h) ? 0 : load_row + 1;
            end else begin
               load_col++;
            end
         end else begin
            addr = emit_source_addr();
            if (emit_col >= dw) emit_col = 0;
            if (emit_row >= dh) emit_row = 0;
            word         = frame[addr];
            px.red       = word[7:0];
            px.green     = word[15:8];
            px.blue      = word[23:16];
            px.alpha     = alpha_reg ? word[31:24] : '0;
            px.col       = COORD_W'(emit_col);
            px.row       = COORD_W'(emit_row);
            px.last_flag = (emit_col + 1 >= dw) && (emit_row + 1 >= dh);
            upcoming_pixels.push_back(px);
            if (emit_col + 1 >= dw) begin
               emit_col = 0;
               emit_row = (emit_row + 1 >= dh) ? 0 : emit_row + 1;
            end else begin
               emit_col++;
            end
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want,
                       rotated_pixel_type want_px);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h at col %0d row %0d",
                                      name, got, want, want_px.col, want_px.row));
      endtask

      task check_response(rotated_pixel_type got);
         rotated_pixel_type want;
         if (upcoming_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel at col %0d row %0d", got.col, got.row));
         end else begin
            want = upcoming_pixels.pop_front();
            check_field("red",   got.red,   want.red,   want);
            check_field("green", got.green, want.green, want);
            check_field("blue",  got.blue,  want.blue,  want);
            check_field("alpha", got.alpha, want.alpha, want);
            check_field("col",   PIX_W'(got.col), PIX_W'(want.col), want);
            check_field("row",   PIX_W'(got.row), PIX_W'(want.row), want);
            check_field("last",  PIX_W'(got.last_flag), PIX_W'(want.last_flag), want);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   ifr_req_if req_bus ();
   ifr_rsp_if rsp_bus ();

   rotation_tracker   tracker = new();
   rotated_pixel_type seen_pixel;
   bit                quiet        = 1'b0;
   bit                hold_request = 1'b0;
   int unsigned       items_sent   = 0;
   int unsigned       cycle_count  = 0;

   image_frame_rotator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_cmd_type'(req_bus.command),
                                 {req_bus.in_alpha, req_bus.in_blue,
                                  req_bus.in_green, req_bus.in_red});
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_pixel.red       = rsp_bus.out_red;
            seen_pixel.green     = rsp_bus.out_green;
            seen_pixel.blue      = rsp_bus.out_blue;
            seen_pixel.alpha     = rsp_bus.out_alpha;
            seen_pixel.col       = rsp_bus.out_col;
            seen_pixel.row       = rsp_bus.out_row;
            seen_pixel.last_flag = rsp_bus.last_pixel;
            tracker.check_response(seen_pixel);
         end
      end
   end

   // drop ready at random, and hold it low once for a long stretch so the block backs up
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : 1)
               @(negedge clock);
         end
      end
   end

   function automatic logic [WORD_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_size();
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return $urandom_range(MAX_DIM + 1, SIZE_REG_MAX);
         2:       return MAX_DIM;
         3, 4, 5: return $urandom_range(7, 16);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   task automatic send_item(req_cmd_type cmd, logic [WORD_W-1:0] pixel);
      if (!quiet && $urandom_range(0, 11) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      {req_bus.in_alpha, req_bus.in_blue, req_bus.in_green, req_bus.in_red} <= pixel;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_pixels(int unsigned count);
      repeat (count) send_item(CMD_LOAD, random_pixel());
   endtask

   // swap an emit for a load while its source entry has never been written
   task automatic emit_pixels(int unsigned count);
      repeat (count) begin
         if (tracker.emit_is_safe())
            send_item(CMD_EMIT, random_pixel());
         else
            send_item(CMD_LOAD, random_pixel());
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type index, int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_DATA_W'(value);
      @(posedge clock);
      tracker.set_register(index, CSR_DATA_W'(value));
      @(negedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h, rot_mode_type mode,
                            bit alpha, bit every_reg);
      drain();
      write_register(CSR_SOURCE_WIDTH, w);
      write_register(CSR_SOURCE_HEIGHT, h);
      if (every_reg || $urandom_range(0, 3) != 0) write_register(CSR_ROTATION_MODE, mode);
      if (every_reg || $urandom_range(0, 3) != 0) write_register(CSR_ALPHA_PRESENT, alpha);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned w, h;
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = CSR_SOURCE_WIDTH;
      csr_write_data          = '0;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_LOAD;
      req_bus.in_red          = '0;
      req_bus.in_green        = '0;
      req_bus.in_blue         = '0;
      req_bus.in_alpha        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero width, mode three, alpha dropped, emit wraps past the last pixel
      configure(0, 3, ROT_180_B, 1'b0, 1'b1);
      send_item(CMD_LOAD, 32'h0000_0000);
      send_item(CMD_LOAD, 32'hFFFF_FFFF);
      send_item(CMD_LOAD, 32'h5AA5_C33C);
      emit_pixels(4);
      configure(2, 2, ROT_CW90, 1'b1, 1'b1);
      send_item(CMD_LOAD, 32'hFFFF_FFFF);
      send_item(CMD_LOAD, 32'h0000_0000);
      send_item(CMD_LOAD, 32'hA5A5_A5A5);
      send_item(CMD_LOAD, 32'h5A5A_5A5A);
      emit_pixels(4);
      configure(2, 2, ROT_CCW90, 1'b1, 1'b1);
      emit_pixels(4);
      configure(2, 2, ROT_180, 1'b1, 1'b1);
      emit_pixels(4);

      configure(MAX_DIM, PRESSURE_ROWS, rot_mode_type'($urandom_range(0, 3)), 1'b1, 1'b1);
      load_pixels(MAX_DIM * PRESSURE_ROWS);
      hold_request = 1'b1;
      emit_pixels(MAX_DIM * PRESSURE_ROWS);

      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= QUIET_AFTER) quiet = 1'b1;
         w = pick_size();
         h = pick_size();
         if (tracker.bounded(CFG_SIZE_W'(w)) * tracker.bounded(CFG_SIZE_W'(h)) > 256)
            h = $urandom_range(1, 4);
         configure(w, h, rot_mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0);
         if ($urandom_range(0, 3) != 0) begin
            load_pixels(tracker.source_pixels());
            emit_pixels(tracker.dest_pixels() * $urandom_range(1, 2));
         end else begin
            repeat ($urandom_range(1, 30)) begin
               if ($urandom_range(0, 1) == 0)
                  load_pixels(1);
               else
                  emit_pixels(1);
            end
         end
      end

      drain();
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
